// ===== hw/rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Types and constants shared by the phase posterior update controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam logic [16:0] ONE16    = 17'd65536;
    localparam logic [26:0] R_SCALE  = 27'd100000000;
    localparam logic [26:0] R_CAP    = 27'd99000000;
    localparam logic [30:0] SPAN_MAX = 31'd10000000;
    localparam logic [23:0] PC_RESET = 24'd65536;
    localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam int          DIV_STEPS = 17;
    localparam int          ITER_W    = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic REG_PSEUDO  = 1'b0;
    localparam logic REG_SPATIAL = 1'b1;

    // leg phase codes
    localparam logic [1:0] LEG_ZERO = 2'd1;
    localparam logic [1:0] LEG_ONE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_FIN, ST_DSET, ST_DITER, ST_DWR,
        ST_DMUL, ST_SPCHK, ST_SPMUL, ST_SPCMP, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_ACC, OP_ONEHOT, OP_DEGEN, OP_ZERO,
        OP_DSET, OP_DITER, OP_DWRITE, OP_DMUL, OP_SP_PREP, OP_SP_MUL, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        DM_RATIO, DM_FRAC, DM_SPAT
    } t_dmode;

    typedef struct packed {
        t_op        op;
        t_dmode     mode;
        logic [1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       in_finish;
        logic       k0;
        logic       k1;
        logic [1:0] ib;
        logic [1:0] ia;
        logic       total_zero;
        logic       den_zero;
        logic       sp_req;
        logic       sp_skip0;
        logic       sp_skip1;
        logic       out_free;
    } t_stat;

endpackage

// ===== hw/rtl/ppu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppu_ctrl
// Sequencer for accumulation, the shared divider passes and the spatial
// adjustment.
// ----------------------------------------------------------------------------
module ppu_ctrl
    import ppu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state              r_state, n_state;
    t_dmode              r_mode,  n_mode;
    logic [1:0]          r_idx,   n_idx;
    logic [1:0]          r_left,  n_left;
    logic [ITER_W-1:0]   r_iter,  n_iter;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= DM_RATIO;
            r_idx   <= 2'd0;
            r_left  <= 2'd0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_iter  <= n_iter;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_left     = r_left;
        n_iter     = r_iter;
        o_cmd.op   = OP_NONE;
        o_cmd.mode = r_mode;
        o_cmd.idx  = r_idx;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = i_stat.in_finish ? ST_FIN : ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_IDLE;
            end
            ST_FIN: begin
                if (i_stat.k0 && i_stat.k1) begin
                    o_cmd.op = OP_ONEHOT;
                    n_state  = ST_SPCHK;
                end else if (i_stat.total_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = ST_EMIT;
                end else if (!i_stat.k0 && !i_stat.k1) begin
                    o_cmd.op = OP_ZERO;
                    n_mode   = DM_RATIO;
                    n_idx    = 2'd0;
                    n_left   = 2'd3;
                    n_state  = ST_DSET;
                end else if (i_stat.den_zero) begin
                    o_cmd.op = OP_DEGEN;
                    n_state  = ST_EMIT;
                end else begin
                    o_cmd.op = OP_ZERO;
                    n_mode   = DM_FRAC;
                    n_idx    = i_stat.ia;
                    n_left   = 2'd1;
                    n_state  = ST_DSET;
                end
            end
            ST_DMUL: begin
                o_cmd.op = OP_DMUL;
                n_state  = ST_DSET;
            end
            ST_DSET: begin
                o_cmd.op = OP_DSET;
                n_iter   = '0;
                n_state  = ST_DITER;
            end
            ST_DITER: begin
                o_cmd.op = OP_DITER;
                if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DWR;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_DWR: begin
                o_cmd.op = OP_DWRITE;
                if (r_left != 2'd0) begin
                    n_left  = r_left - 1'b1;
                    n_idx   = (r_mode == DM_FRAC) ? i_stat.ib : r_idx + 1'b1;
                    n_state = (r_mode == DM_SPAT) ? ST_DMUL : ST_DSET;
                end else begin
                    n_state = (r_mode == DM_SPAT) ? ST_EMIT : ST_SPCHK;
                end
            end
            ST_SPCHK: begin
                if (i_stat.sp_req && !i_stat.sp_skip0) begin
                    o_cmd.op = OP_SP_PREP;
                    n_state  = ST_SPMUL;
                end else begin
                    n_state  = ST_EMIT;
                end
            end
            ST_SPMUL: begin
                o_cmd.op = OP_SP_MUL;
                n_state  = ST_SPCMP;
            end
            ST_SPCMP: begin
                if (i_stat.sp_skip1) begin
                    n_state = ST_EMIT;
                end else begin
                    n_mode  = DM_SPAT;
                    n_idx   = 2'd0;
                    n_left  = 2'd3;
                    n_state = ST_DMUL;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ppu_dp.sv =====
// ----------------------------------------------------------------------------
// ppu_dp
// Sums, shared restoring divider, spatial adjustment operands, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module ppu_dp
    import ppu_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic         i_s_tuser,
    input  logic [127:0] i_s_tdata,
    input  logic         i_cfg_valid,
    input  logic [0:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,
    output logic         o_m_tuser
);

    logic [23:0] r_pc;
    logic        r_spen;
    logic [47:0] r_sum [4];
    logic [47:0] r_total;
    logic [40:0] r_prd [4];
    logic [23:0] r_w;
    logic [1:0]  r_leg0, r_leg1;
    logic        r_chrom;
    logic [30:0] r_span;
    logic [16:0] r_post [4];
    logic        r_degen;
    logic [65:0] r_rem, r_dsh;
    logic [16:0] r_q;
    logic        r_sat;
    logic [17:0] r_a, r_b;
    logic [26:0] r_r, r_nr;
    logic [44:0] r_ma, r_mb;
    logic [43:0] r_prod;
    logic        r_ovalid;
    logic [16:0] r_opost [4];
    logic        r_odegen;

    logic [63:0] seed_sum_w, seed_tot_w, rst_sum_w, rst_tot_w;
    logic        b0, b1;
    logic [1:0]  ia, ib;
    logic [48:0] den;
    logic [17:0] a_now, b_now;
    logic [26:0] span_diff;
    logic [44:0] m_sel;
    logic [65:0] x_sel;
    logic [49:0] d_sel;
    logic [17:0] q_rnd;
    logic [16:0] q_res;
    logic        hit;

    // reseed values for the current and the reset pseudo-count
    assign seed_sum_w = 64'(r_pc) << (WEIGHT_FRAC_BITS - 2);
    assign seed_tot_w = (64'(r_pc) << WEIGHT_FRAC_BITS) >> 16;
    assign rst_sum_w  = 64'(PC_RESET) << (WEIGHT_FRAC_BITS - 2);
    assign rst_tot_w  = (64'(PC_RESET) << WEIGHT_FRAC_BITS) >> 16;

    // leg decode and the pair of states that agree with a known leg
    assign b0 = (r_leg0 == LEG_ONE);
    assign b1 = (r_leg1 == LEG_ONE);
    assign o_stat.k0 = (r_leg0 == LEG_ZERO) || (r_leg0 == LEG_ONE);
    assign o_stat.k1 = (r_leg1 == LEG_ZERO) || (r_leg1 == LEG_ONE);
    assign ia  = o_stat.k0 ? {b0, 1'b0} : {1'b0, b1};
    assign ib  = o_stat.k0 ? {b0, 1'b1} : {1'b1, b1};
    assign den = {1'b0, r_sum[ia]} + {1'b0, r_sum[ib]};

    assign a_now     = {1'b0, r_post[0]} + {1'b0, r_post[3]};
    assign b_now     = {1'b0, r_post[1]} + {1'b0, r_post[2]};
    assign span_diff = R_SCALE - r_span[26:0];

    assign o_stat.in_finish  = i_s_tuser;
    assign o_stat.ia         = ia;
    assign o_stat.ib         = ib;
    assign o_stat.total_zero = (r_total == 48'd0);
    assign o_stat.den_zero   = (den == 49'd0);
    assign o_stat.sp_req     = r_spen && r_chrom;
    assign o_stat.sp_skip0   = (a_now == 18'd0) || (b_now == 18'd0) || (r_span > SPAN_MAX);
    assign o_stat.sp_skip1   = (45'({r_r, 16'b0}) < r_ma);
    assign o_stat.out_free   = !r_ovalid || i_m_tready;

    // divider operands for the three kinds of division
    always_comb begin
        m_sel = (i_cmd.idx == 2'd0 || i_cmd.idx == 2'd3) ? r_ma : r_mb;
        case (i_cmd.mode)
            DM_RATIO: begin
                x_sel = 66'({r_sum[i_cmd.idx], 1'b0}) + 66'(r_total);
                d_sel = 50'({r_total, 1'b0});
            end
            DM_FRAC: begin
                x_sel = 66'({r_sum[i_cmd.idx], 17'b0});
                d_sel = 50'(den);
            end
            default: begin
                x_sel = 66'({r_prod, 17'b0}) + 66'(m_sel);
                d_sel = 50'({m_sel, 1'b0});
            end
        endcase
    end

    // divider result with rounding and saturation
    always_comb begin
        q_rnd = (18'(r_q) + 18'd1) >> 1;
        case (i_cmd.mode)
            DM_RATIO: q_res = (r_sat || r_q > ONE16) ? ONE16 : r_q;
            DM_FRAC:  q_res = (r_sat || q_rnd > 18'(ONE16)) ? ONE16 : q_rnd[16:0];
            default:  q_res = (r_q > ONE16) ? ONE16 : r_q;
        endcase
    end

    assign hit = (r_rem >= r_dsh);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_RESET;
            r_spen <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PSEUDO:  r_pc   <= i_cfg_data;
                REG_SPATIAL: r_spen <= i_cfg_data[0];
                default:     r_pc   <= r_pc;
            endcase
        end
    end

    // sums and total: seed, accumulate with saturation, reseed on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_sum[j] <= rst_sum_w[47:0];
            r_total <= rst_tot_w[47:0];
        end else if (i_cmd.op == OP_ACC) begin
            for (int j = 0; j < 4; j++) begin
                logic [48:0] t;
                t = {1'b0, r_sum[j]} + 49'(r_prd[j]);
                r_sum[j] <= t[48] ? SUM_MAX : t[47:0];
            end
            begin
                logic [48:0] tw;
                tw = {1'b0, r_total} + 49'(r_w);
                r_total <= tw[48] ? SUM_MAX : tw[47:0];
            end
        end else if (i_cmd.op == OP_EMIT) begin
            for (int j = 0; j < 4; j++) r_sum[j] <= seed_sum_w[47:0];
            r_total <= seed_tot_w[47:0];
        end
    end

    // capture the item; form the neighbour products
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CAPTURE) begin
            r_w     <= i_s_tdata[23:0];
            r_prd[0] <= 41'(i_s_tdata[23:0]) * 41'(i_s_tdata[40:24]);
            r_prd[1] <= 41'(i_s_tdata[23:0]) * 41'(i_s_tdata[57:41]);
            r_prd[2] <= 41'(i_s_tdata[23:0]) * 41'(i_s_tdata[74:58]);
            r_prd[3] <= 41'(i_s_tdata[23:0]) * 41'(i_s_tdata[91:75]);
            r_leg0  <= i_s_tdata[93:92];
            r_leg1  <= i_s_tdata[95:94];
            r_chrom <= i_s_tdata[96];
            r_span  <= i_s_tdata[127:97];
        end
    end

    // posteriors, divider and spatial operands
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ONEHOT: begin
                for (int j = 0; j < 4; j++)
                    r_post[j] <= (2'(j) == {b0, b1}) ? ONE16 : 17'd0;
                r_degen <= 1'b0;
            end
            OP_DEGEN, OP_ZERO: begin
                for (int j = 0; j < 4; j++) r_post[j] <= 17'd0;
                r_degen <= (i_cmd.op == OP_DEGEN);
            end
            OP_DMUL: begin
                r_prod <= 44'((i_cmd.idx == 2'd0 || i_cmd.idx == 2'd3) ? r_r : r_nr)
                          * 44'(r_post[i_cmd.idx]);
            end
            OP_DSET: begin
                r_rem <= x_sel;
                r_dsh <= {d_sel, 16'b0};
                r_q   <= 17'd0;
                r_sat <= ({1'b0, x_sel} >= {d_sel, 17'b0});
            end
            OP_DITER: begin
                if (hit) r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[15:0], hit};
                r_dsh <= r_dsh >> 1;
            end
            OP_DWRITE: begin
                r_post[i_cmd.idx] <= q_res;
            end
            OP_SP_PREP: begin
                r_a  <= a_now;
                r_b  <= b_now;
                r_r  <= (span_diff > R_CAP) ? R_CAP : span_diff;
                r_nr <= R_SCALE - ((span_diff > R_CAP) ? R_CAP : span_diff);
            end
            OP_SP_MUL: begin
                r_ma <= 45'(r_a) * 45'(R_SCALE);
                r_mb <= 45'(r_b) * 45'(R_SCALE);
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            for (int j = 0; j < 4; j++) r_opost[j] <= r_post[j];
            r_odegen <= r_degen;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_opost[3], r_opost[2], r_opost[1], r_opost[0]};
    assign o_m_tuser  = r_odegen;

endmodule

// ===== hw/rtl/phase_posterior_update.sv =====
// ----------------------------------------------------------------------------
// phase_posterior_update
// One EM update of the four phase probabilities of a contact pair.
//
// channel   direction  handshake             payload
// s_axis    in         i_s_tvalid/o_s_tready tdata item fields, tuser kind
// m_axis    out        o_m_tvalid/i_m_tready tdata posteriors, tuser degenerate
// cfg       in         i_cfg_valid/o_cfg_ready index 0 pseudo_count, 1 spatial
//
// A neighbour transaction takes capture and multiply, then saturating add.
// A finish transaction takes capture, decode, spatial check and emit, plus
// a pass of the shared 17-step restoring divider per divided posterior: 4
// passes with both legs unknown, 2 with one known, none with both known; a
// zero total skips the divider. The spatial adjustment adds a multiply, a
// compare and 4 passes. One item is in work at a time; the output register
// lets the next item enter while a result waits. Reset is synchronous and
// reseeds the sums at once; a stalled output holds only the final emit.
// ----------------------------------------------------------------------------
module phase_posterior_update
    import ppu_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // weight[23:0] prior_0[40:24] prior_1[57:41] prior_2[74:58] prior_3[91:75]
    // leg0_phase[93:92] leg1_phase[95:94] same_chrom[96] pair_span[127:97]
    input  logic [127:0] i_s_tdata,
    // kind[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // post_0[16:0] post_1[33:17] post_2[50:34] post_3[67:51], zero pad
    output logic [71:0]  o_m_tdata,
    // degenerate[0]
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    ppu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    ppu_dp #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// ===== test/phase_posterior_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_posterior_update_checker
// Watches the input, output and register channels of the phase posterior
// update, predicts each posterior from its own copy of the sums, and
// compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module phase_posterior_update_checker
    import ppu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_posts_seen,
    output int           o_degen_seen
);

    localparam int FRAC = 16;
    localparam longint unsigned SAT = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint unsigned ONE = 64'd65536;
    localparam longint unsigned RSC = 64'd100000000;

    typedef struct packed {
        logic [16:0] post_3;
        logic [16:0] post_2;
        logic [16:0] post_1;
        logic [16:0] post_0;
        logic        degenerate;
    } t_posterior;

    longint unsigned pseudo;
    logic            spatial_on;
    longint unsigned phase_sum [4];
    longint unsigned wt_total;
    t_posterior      posterior_q[$];

    function automatic void reseed_sums();
        for (int j = 0; j < 4; j++) phase_sum[j] = pseudo << (FRAC - 2);
        wt_total = (pseudo << FRAC) >> 16;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SAT) ? SAT : s;
    endfunction

    // restoring division with rounding, numerator below denominator
    function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
        longint unsigned rem, quo;
        rem = num;
        quo = 0;
        if (num >= den) return ONE;
        for (int i = 0; i < 17; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        quo = (quo + 1) >> 1;
        return (quo > ONE) ? ONE : quo;
    endfunction

    function automatic longint unsigned round_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = (2 * num + den) / (2 * den);
        return (q > ONE) ? ONE : q;
    endfunction

    // update the sums on a neighbour, or form the posterior on a finish
    function automatic bit predict_posterior(logic kind, logic [127:0] d, output t_posterior res);
        longint unsigned p [4];
        longint unsigned w, a, b, r, nr, den, span;
        logic [1:0] l0, l1;
        bit k0, k1, degen;
        int ia, ib, b0, b1;
        for (int j = 0; j < 4; j++) p[j] = 0;
        degen = 0;
        res = '0;
        if (!kind) begin
            w = d[23:0];
            for (int j = 0; j < 4; j++)
                phase_sum[j] = add_sat(phase_sum[j], w * longint'(d[24 + 17 * j +: 17]));
            wt_total = add_sat(wt_total, w);
            return 0;
        end
        l0 = d[93:92];
        l1 = d[95:94];
        k0 = (l0 == LEG_ZERO) || (l0 == LEG_ONE);
        k1 = (l1 == LEG_ZERO) || (l1 == LEG_ONE);
        b0 = (l0 == LEG_ONE);
        b1 = (l1 == LEG_ONE);
        if (k0 && k1) begin
            p[b0 * 2 + b1] = ONE;
        end else if (wt_total == 0) begin
            degen = 1;
        end else if (!k0 && !k1) begin
            for (int j = 0; j < 4; j++) p[j] = round_ratio(phase_sum[j], wt_total);
        end else begin
            if (k0) begin
                ia = b0 * 2;
                ib = ia + 1;
            end else begin
                ia = b1;
                ib = ia + 2;
            end
            den = phase_sum[ia] + phase_sum[ib];
            if (den == 0) begin
                degen = 1;
            end else begin
                p[ia] = frac_q16(phase_sum[ia], den);
                p[ib] = frac_q16(phase_sum[ib], den);
            end
        end
        // shift mass toward the cis states for short spans
        span = d[127:97];
        if (!degen && spatial_on && d[96]) begin
            a = p[0] + p[3];
            b = p[1] + p[2];
            r = (span > 10000000) ? 0 : RSC - span;
            if (r > 99000000) r = 99000000;
            if (a != 0 && b != 0 && span <= 10000000 && !(r * ONE < a * RSC)) begin
                nr = RSC - r;
                p[0] = (2 * r * p[0] * ONE + RSC * a) / (2 * RSC * a);
                p[3] = (2 * r * p[3] * ONE + RSC * a) / (2 * RSC * a);
                p[1] = (2 * nr * p[1] * ONE + RSC * b) / (2 * RSC * b);
                p[2] = (2 * nr * p[2] * ONE + RSC * b) / (2 * RSC * b);
            end
        end
        res.post_0 = p[0][16:0];
        res.post_1 = p[1][16:0];
        res.post_2 = p[2][16:0];
        res.post_3 = p[3][16:0];
        res.degenerate = degen;
        reseed_sums();
        return 1;
    endfunction

    assign o_pending = posterior_q.size();

    // track registers, predict on input transactions, compare outputs
    always @(posedge i_clk) begin
        t_posterior exp_r, got;
        if (!i_rst_n) begin
            pseudo = PC_RESET;
            spatial_on = 1'b0;
            reseed_sums();
            posterior_q.delete();
            o_errors = 0;
            o_posts_seen = 0;
            o_degen_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_PSEUDO) pseudo = i_cfg_data;
                else spatial_on = i_cfg_data[0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (predict_posterior(i_s_tuser, i_s_tdata, exp_r))
                    posterior_q.push_back(exp_r);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.post_0 = i_m_tdata[16:0];
                got.post_1 = i_m_tdata[33:17];
                got.post_2 = i_m_tdata[50:34];
                got.post_3 = i_m_tdata[67:51];
                got.degenerate = i_m_tuser;
                o_posts_seen++;
                if (got.degenerate) o_degen_seen++;
                if (posterior_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%t: unexpected output transaction %h", $realtime, got);
                end else begin
                    exp_r = posterior_q.pop_front();
                    if (got !== exp_r) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%t: mismatch p0 %0d/%0d p1 %0d/%0d p2 %0d/%0d p3 %0d/%0d dg %0d/%0d",
                                $realtime, exp_r.post_0, got.post_0, exp_r.post_1, got.post_1,
                                exp_r.post_2, got.post_2, exp_r.post_3, got.post_3,
                                exp_r.degenerate, got.degenerate);
                    end
                end
            end
        end
    end

endmodule

// ===== test/phase_posterior_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_posterior_update_tb
// Drives neighbour and finish transactions through the phase posterior
// update under several register settings and idling patterns; the checker
// beside the block predicts and compares every posterior.
// ----------------------------------------------------------------------------
module phase_posterior_update_tb;
    import ppu_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    int errors, pending, posts_seen, degen_seen;
    int items_sent = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit long_hold_req = 0;

    always #2 i_clk = ~i_clk;

    phase_posterior_update u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    phase_posterior_update_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_posts_seen(posts_seen), .o_degen_seen(degen_seen)
    );

    // stall the output at random; hold off for a long stretch on request
    always @(posedge i_clk) begin
        int hold;
        if (long_hold_req) begin
            m_tready <= 1'b0;
            hold = 0;
            while (hold < 400) begin
                @(posedge i_clk);
                hold++;
            end
            long_hold_req = 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // offer one transaction, with an optional idle gap in front
    task automatic send_item(logic kind, logic [127:0] payload);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= payload;
        forever begin
            @(negedge i_clk);
            if (s_tready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every posterior, then let the datapath settle
    task automatic drain();
        drop_valid();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge i_clk);
            if (cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [127:0] pack_item(logic [23:0] w, logic [16:0] p0, logic [16:0] p1,
            logic [16:0] p2, logic [16:0] p3, logic [1:0] l0, logic [1:0] l1, logic same,
            logic [30:0] span);
        return {span, same, l1, l0, p3, p2, p1, p0, w};
    endfunction

    function automatic logic [16:0] rand_prior();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return ONE16;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [23:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [30:0] rand_span();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 31'h7FFFFFFF));
            1: return 31'($urandom_range(9999990, 10000010));
            2: return 31'($urandom_range(0, 1000));
            default: return 31'($urandom_range(0, 10000000));
        endcase
    endfunction

    task automatic send_neighbour();
        send_item(1'b0, pack_item(rand_weight(), rand_prior(), rand_prior(), rand_prior(),
            rand_prior(), 2'($urandom), 2'($urandom), 1'($urandom), 31'($urandom)));
    endtask

    task automatic send_finish();
        send_item(1'b1, pack_item(24'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
            17'($urandom), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            1'($urandom_range(0, 1)), rand_span()));
    endtask

    // well-formed pairs: a few neighbours then a finish; some stray finishes
    task automatic random_pairs(int count);
        int n;
        while (count > 0) begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            repeat (n) begin
                send_neighbour();
                count--;
            end
            send_finish();
            count--;
        end
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
            default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
        endcase
    endtask

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset seeds, every leg combination, extremes
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++) begin
                send_item(1'b0, pack_item(24'h010000, 17'd40000, 17'd10000, 17'd5000,
                    17'd10536, 0, 0, 0, 0));
                send_item(1'b1, pack_item(0, 0, 0, 0, 0, 2'(a), 2'(b), 0, 0));
            end
        send_item(1'b0, pack_item(24'hFFFFFF, ONE16, ONE16, ONE16, ONE16, 3, 3, 1,
            31'h7FFFFFFF));
        send_item(1'b1, pack_item(24'hFFFFFF, ONE16, ONE16, ONE16, ONE16, 0, 0, 1,
            31'h7FFFFFFF));
        write_reg(REG_SPATIAL, 24'd1);
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 0, 0, 1, 0));
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 1, 0, 1, 31'd10000000));
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 0, 2, 1, 31'd10000001));
        write_reg(REG_PSEUDO, 24'd0);
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 0, 0, 1, 0));
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 2, 0, 1, 0));
        send_item(1'b0, pack_item(24'h020000, 0, ONE16, 0, 0, 0, 0, 0, 0));
        send_item(1'b1, pack_item(0, 0, 0, 0, 0, 1, 0, 1, 100));

        // random phases over several register settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(REG_PSEUDO, 24'hFFFFFF);
                1: write_reg(REG_SPATIAL, 24'd0);
                2: write_reg(REG_PSEUDO, 24'd1);
                3: write_reg(REG_SPATIAL, 24'hFFFFFF);
                4: write_reg(REG_PSEUDO, PC_RESET);
                default: write_reg(REG_PSEUDO, 24'($urandom_range(0, 24'hFFFFFF)));
            endcase
            set_idling(phase);
            if (phase == 5) begin
                drop_valid();
                long_hold_req = 1;
                tx_idle_pct = 0;
            end
            random_pairs(230);
            if (phase == 6) begin
                drain();
            end
        end

        drain();
        $display("Sent %0d transactions; %0d posteriors checked, %0d degenerate.",
            items_sent, posts_seen, degen_seen);
        $display("Covered all leg codes, spatial on and off, pseudo-count extremes.");
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
